>>> sv/mhts_pkg.sv
// ============================================================================
// mhts_pkg: shared types and constants of the heap timer scheduler
// Holds the heap depth, the entry layout and the transaction codes.
// ============================================================================
`default_nettype none

package mhts_pkg;

    localparam int DEPTH    = 64;
    localparam int TAG_BITS = 16;
    localparam int MAX_FIRE = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [63:0]         expiry;
        logic [31:0]         ident;
        logic [TAG_BITS-1:0] handle;
        logic                dead;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/min_heap_timer_scheduler.sv
// ============================================================================
// min_heap_timer_scheduler: timer queue over a binary min-heap
// Adds timers, cancels them by id and fires expired ones on millisecond ticks.
// ============================================================================
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------------------
//  command   | start, busy (taken when  | kind, delay_ms, timer_id, tag
//            | start and not busy)      |
//  result    | result_valid (one cycle) | result_kind, result_id, result_tag,
//            |                          | status, last
//
// Each transaction but an add to a full heap runs through the state machine
// with busy high throughout. An add climbs the heap from the new slot, moving
// down each parent that is later than the new entry, and ends at the root or
// at an earlier or equal parent. A cancel reads the slots in turn from slot 0
// up to the match, or all of them when the id is not found. A tick pops each
// expired entry at the root, moves the last entry into the hole and sinks it
// level by level until it settles, bound by the single heap memory port, one
// read and one write per cycle. Reset clears the clock and the entry count and
// sets the id counter to 1 at once; no clearing pass is needed since only slots
// below the count are ever used. Results cannot be stalled.
//
`default_nettype none

module min_heap_timer_scheduler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [31:0]                 delay_ms,
    input  wire logic [31:0]                 timer_id,
    input  wire logic [15:0]                 tag,
    output logic                             result_valid,
    output logic [1:0]                       result_kind,
    output logic [31:0]                      result_id,
    output logic [15:0]                      result_tag,
    output logic [1:0]                       status,
    output logic                             last
);
    import mhts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_CAN_RD, S_CAN_CHK, S_TK_RD, S_TK_CHK,
        S_TK_LAST, S_DN_RD, S_DN_L, S_DN_R, S_TK_END
    } state_t;

    // Heap storage: one entry per slot, one read and one write port.
    entry_t              mem [DEPTH];
    entry_t              rdata_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    state_t              state_reg, state_next;
    logic [63:0]         now_reg, now_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    entry_t              item_reg, item_next;
    entry_t              lchild_reg, lchild_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [31:0]         tid_reg, tid_next;
    logic [FIRE_W-1:0]   fires_reg, fires_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [31:0]         pend_id_reg, pend_id_next;
    logic [15:0]         pend_tag_reg, pend_tag_next;
    logic                rv_reg, rv_next;
    logic [1:0]          rkind_reg, rkind_next;
    logic [31:0]         rid_reg, rid_next;
    logic [15:0]         rtag_reg, rtag_next;
    logic [1:0]          rstat_reg, rstat_next;
    logic                rlast_reg, rlast_next;

    // Child positions of the hole during sift-down, its parent during sift-up.
    logic [CNT_W-1:0]    lpos;
    logic [CNT_W:0]      rpos;
    logic [ADDR_W-1:0]   parent;
    logic [CNT_W-1:0]    count_dec;
    logic                left_less;
    logic [63:0]         best_exp;

    assign lpos      = {pos_reg, 1'b1};
    assign rpos      = {1'b0, lpos} + (CNT_W+1)'(1);
    assign parent    = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign count_dec = count_reg - CNT_W'(1);
    assign left_less = lchild_reg.expiry < item_reg.expiry;
    assign best_exp  = left_less ? lchild_reg.expiry : item_reg.expiry;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        next_id_next    = next_id_reg;
        count_next      = count_reg;
        item_next       = item_reg;
        lchild_next     = lchild_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        tid_next        = tid_reg;
        fires_next      = fires_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        rv_next         = 1'b0;
        rkind_next      = rkind_reg;
        rid_next        = rid_reg;
        rtag_next       = rtag_reg;
        rstat_next      = rstat_reg;
        rlast_next      = rlast_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = item_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_ADD:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                rv_next    = 1'b1;
                                rkind_next = KIND_ADD;
                                rid_next   = '0;
                                rtag_next  = '0;
                                rstat_next = ST_FULL;
                                rlast_next = 1'b1;
                            end
                            else
                            begin
                                next_id_next     = next_id_reg + 32'd1;
                                item_next.expiry = now_reg + {32'd0, delay_ms};
                                item_next.ident  = next_id_reg + 32'd1;
                                item_next.handle = tag[TAG_BITS-1:0];
                                item_next.dead   = 1'b0;
                                pos_next         = count_reg[ADDR_W-1:0];
                                state_next       = S_UP_RD;
                            end
                        end
                        KIND_CANCEL:
                        begin
                            tid_next   = timer_id;
                            idx_next   = '0;
                            state_next = S_CAN_RD;
                        end
                        KIND_TICK:
                        begin
                            now_next        = now_reg + 64'd1;
                            fires_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Sift-up with a hole: parents larger than the new entry move down.
            S_UP_RD:
            begin
                rd_addr = parent;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    rv_next    = 1'b1;
                    rkind_next = KIND_ADD;
                    rid_next   = item_reg.ident;
                    rtag_next  = '0;
                    rstat_next = ST_OK;
                    rlast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rdata_reg.expiry <= item_reg.expiry)
                begin
                    count_next = count_reg + CNT_W'(1);
                    rv_next    = 1'b1;
                    rkind_next = KIND_ADD;
                    rid_next   = item_reg.ident;
                    rtag_next  = '0;
                    rstat_next = ST_OK;
                    rlast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_data    = rdata_reg;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
            end

            // Linear search from slot 0 for the id.
            S_CAN_RD:
            begin
                rd_addr = idx_reg[ADDR_W-1:0];
                if (idx_reg >= count_reg)
                begin
                    rv_next    = 1'b1;
                    rkind_next = KIND_CANCEL;
                    rid_next   = tid_reg;
                    rtag_next  = '0;
                    rstat_next = ST_NOT_FOUND;
                    rlast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CAN_CHK;
                end
            end

            S_CAN_CHK:
            begin
                if (rdata_reg.ident == tid_reg)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg[ADDR_W-1:0];
                    wr_data      = rdata_reg;
                    wr_data.dead = 1'b1;
                    rv_next      = 1'b1;
                    rkind_next   = KIND_CANCEL;
                    rid_next     = tid_reg;
                    rtag_next    = '0;
                    rstat_next   = ST_OK;
                    rlast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_CAN_RD;
                end
            end

            // Pop loop. A fire result is held back one step so that the
            // final one can carry the last flag.
            S_TK_RD:
            begin
                rd_addr = '0;
                if (count_reg == '0 || fires_reg == FIRE_W'(MAX_FIRE))
                begin
                    state_next = S_TK_END;
                end
                else
                begin
                    state_next = S_TK_CHK;
                end
            end

            S_TK_CHK:
            begin
                rd_addr = count_dec[ADDR_W-1:0];
                if (rdata_reg.expiry > now_reg)
                begin
                    state_next = S_TK_END;
                end
                else
                begin
                    count_next = count_dec;
                    if (!rdata_reg.dead)
                    begin
                        if (pend_valid_reg)
                        begin
                            rv_next    = 1'b1;
                            rkind_next = KIND_TICK;
                            rid_next   = pend_id_reg;
                            rtag_next  = pend_tag_reg;
                            rstat_next = ST_OK;
                            rlast_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rdata_reg.ident;
                        pend_tag_next   = 16'(rdata_reg.handle);
                        fires_next      = fires_reg + FIRE_W'(1);
                    end
                    state_next = (count_dec != '0) ? S_TK_LAST : S_TK_RD;
                end
            end

            S_TK_LAST:
            begin
                item_next  = rdata_reg;
                pos_next   = '0;
                state_next = S_DN_RD;
            end

            // Sift-down with a hole at pos_reg, holding the former last entry.
            S_DN_RD:
            begin
                rd_addr = lpos[ADDR_W-1:0];
                if (lpos >= count_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_TK_RD;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end

            S_DN_L:
            begin
                lchild_next = rdata_reg;
                rd_addr     = rpos[ADDR_W-1:0];
                if (rpos < {1'b0, count_reg})
                begin
                    state_next = S_DN_R;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (rdata_reg.expiry < item_reg.expiry)
                    begin
                        wr_data    = rdata_reg;
                        pos_next   = lpos[ADDR_W-1:0];
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        state_next = S_TK_RD;
                    end
                end
            end

            S_DN_R:
            begin
                wr_en = 1'b1;
                if (rdata_reg.expiry < best_exp)
                begin
                    wr_data    = rdata_reg;
                    pos_next   = rpos[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (left_less)
                begin
                    wr_data    = lchild_reg;
                    pos_next   = lpos[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_TK_RD;
                end
            end

            S_TK_END:
            begin
                if (pend_valid_reg)
                begin
                    rv_next    = 1'b1;
                    rkind_next = KIND_TICK;
                    rid_next   = pend_id_reg;
                    rtag_next  = pend_tag_reg;
                    rstat_next = ST_OK;
                    rlast_next = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            next_id_reg    <= 32'd1;
            count_reg      <= '0;
            fires_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            next_id_reg    <= next_id_next;
            count_reg      <= count_next;
            fires_reg      <= fires_next;
            pend_valid_reg <= pend_valid_next;
            rv_reg         <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        lchild_reg   <= lchild_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        tid_reg      <= tid_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
        rkind_reg    <= rkind_next;
        rid_reg      <= rid_next;
        rtag_reg     <= rtag_next;
        rstat_reg    <= rstat_next;
        rlast_reg    <= rlast_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result_kind  = rkind_reg;
    assign result_id    = rid_reg;
    assign result_tag   = rtag_reg;
    assign status       = rstat_reg;
    assign last         = rlast_reg;

endmodule

`default_nettype wire
